// ----- rtl/core/wavhp_pkg.sv -----
// wavhp_pkg: types, codes and constants shared by the wave header parser
// depends on nothing; used by wavhp_divider, wavhp_datapath, wavhp_controller and the top level
`default_nettype none

package wavhp_pkg;

   typedef enum logic [4:0] {
      PH_RIFF,
      PH_SIZE,
      PH_WAVE,
      PH_ID,
      PH_CLEN,
      PH_COMP,
      PH_CHAN,
      PH_RATE,
      PH_AVG,
      PH_ALIGN,
      PH_BITS,
      PH_SKIP,
      PH_DIV,
      PH_DONE
   } phase_type;

   localparam logic [1:0] ACT_BYTE    = 2'd0;
   localparam logic [1:0] ACT_END     = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_TRUNCATED   = 4'd1;
   localparam logic [3:0] ST_BAD_RIFF    = 4'd2;
   localparam logic [3:0] ST_BAD_WAVE    = 4'd3;
   localparam logic [3:0] ST_COMPRESSION = 4'd4;
   localparam logic [3:0] ST_BITS        = 4'd5;
   localparam logic [3:0] ST_UNKNOWN     = 4'd6;
   localparam logic [3:0] ST_EXHAUSTED   = 4'd7;
   localparam logic [3:0] ST_NO_CHANNELS = 4'd8;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] PCM_CODE = 16'd1;
   localparam logic [15:0] PCM_BITS = 16'd16;

   typedef struct packed {
      logic       capture;
      logic       assemble_be;
      logic [1:0] byte_idx;
      logic       field_done;
      logic       dec_riff;
      logic       dec_chunk;
      logic       load_riff;
      logic       load_chunk;
      logic       load_tag;
      logic       load_chan;
      logic       load_rate;
      logic       load_align;
      logic       load_bits;
      logic       clear_all;
      logic       emit;
      logic [3:0] emit_status;
      logic       use_quotient;
      logic       start_div;
   } wavhp_cmd_type;

   typedef struct packed {
      logic eq_riff;
      logic eq_wave;
      logic tag_fmt;
      logic tag_data;
      logic comp_ok;
      logic bits_ok;
      logic chan_zero;
      logic riff_zero;
      logic riff_one;
      logic chunk_one;
      logic div_done;
      logic out_busy;
   } wavhp_stat_type;

   // index of the last byte of the field read in each phase
   function automatic logic [1:0] field_last(input phase_type p);
      logic [1:0] n;
      case (p)
         PH_COMP, PH_CHAN, PH_ALIGN, PH_BITS: n = 2'd1;
         PH_SKIP: n = 2'd0;
         default: n = 2'd3;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wavhp_req_if.sv -----
// wavhp_req_if: input word channel of the wave header parser
// depends on nothing
`default_nettype none

interface wavhp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink (input valid, action, data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wavhp_rsp_if.sv -----
// wavhp_rsp_if: result word channel of the wave header parser
// depends on nothing
`default_nettype none

interface wavhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [15:0] channels;
   logic [31:0] sample_rate;
   logic [15:0] block_align;
   logic [15:0] bits_per_sample;
   logic [31:0] samples_per_channel;
   logic [31:0] riff_bytes_left;

   modport source (output valid, status, channels, sample_rate, block_align,
                   bits_per_sample, samples_per_channel, riff_bytes_left,
                   input ready);
   modport sink (input valid, status, channels, sample_rate, block_align,
                 bits_per_sample, samples_per_channel, riff_bytes_left,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wavhp_divider.sv -----
// wavhp_divider: iterative restoring divider, 32-bit by 16-bit, one bit a cycle
// depends on wavhp_pkg
`default_nettype none

module wavhp_divider
   import wavhp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] quot_ff, quot_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;

   logic [16:0] shifted;
   logic [16:0] diff;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quot_ff[31]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = shifted >= {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quot_in  = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[30:0], ge};
         rem_in   = ge ? diff[15:0] : shifted[15:0];
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ----- rtl/core/wavhp_datapath.sv -----
// wavhp_datapath: field assembly, size counters, header fields and result register
// depends on wavhp_pkg and wavhp_divider
`default_nettype none

module wavhp_datapath
   import wavhp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire wavhp_cmd_type  cmd,
   input  wire logic [7:0]     data_byte,
   output wavhp_stat_type      stat,
   input  wire logic           rsp_ready,
   output logic                rsp_valid,
   output logic [3:0]          rsp_status,
   output logic [15:0]         rsp_channels,
   output logic [31:0]         rsp_sample_rate,
   output logic [15:0]         rsp_block_align,
   output logic [15:0]         rsp_bits_per_sample,
   output logic [31:0]         rsp_samples_per_channel,
   output logic [31:0]         rsp_riff_bytes_left
);

   logic [31:0] field_shift_ff, field_shift_in;
   logic [31:0] riff_left_ff, riff_left_in;
   logic [31:0] chunk_left_ff, chunk_left_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [15:0] channel_count_ff, channel_count_in;
   logic [31:0] rate_value_ff, rate_value_in;
   logic [15:0] align_value_ff, align_value_in;
   logic [15:0] sample_bits_ff, sample_bits_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  out_status_ff;
   logic [15:0] out_channels_ff;
   logic [31:0] out_rate_ff;
   logic [15:0] out_align_ff;
   logic [15:0] out_bits_ff;
   logic [31:0] out_samples_ff;
   logic [31:0] out_riff_ff;

   logic [31:0] assembled;
   logic [31:0] shift_le;
   logic [31:0] riff_dec;
   logic        div_done;
   logic [31:0] quotient;

   wavhp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (assembled),
      .divisor  (channel_count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      shift_le  = {24'd0, data_byte} << {cmd.byte_idx, 3'b000};
      assembled = cmd.assemble_be ? {field_shift_ff[23:0], data_byte}
                                  : (field_shift_ff | shift_le);
      riff_dec  = riff_left_ff - {31'd0, cmd.dec_riff};
   end

   always_comb begin
      field_shift_in   = field_shift_ff;
      riff_left_in     = riff_dec;
      chunk_left_in    = chunk_left_ff;
      chunk_tag_in     = chunk_tag_ff;
      channel_count_in = channel_count_ff;
      rate_value_in    = rate_value_ff;
      align_value_in   = align_value_ff;
      sample_bits_in   = sample_bits_ff;
      if (cmd.capture) begin
         field_shift_in = cmd.field_done ? '0 : assembled;
      end
      if (cmd.load_riff) begin
         riff_left_in = assembled;
      end else if (cmd.load_chunk) begin
         riff_left_in = riff_dec - assembled;
      end
      if (cmd.load_chunk) begin
         chunk_left_in = assembled;
      end else if (cmd.dec_chunk) begin
         chunk_left_in = chunk_left_ff - 32'd1;
      end
      if (cmd.load_tag) begin
         chunk_tag_in = assembled;
      end
      if (cmd.load_chan) begin
         channel_count_in = assembled[15:0];
      end
      if (cmd.load_rate) begin
         rate_value_in = assembled;
      end
      if (cmd.load_align) begin
         align_value_in = assembled[15:0];
      end
      if (cmd.load_bits) begin
         sample_bits_in = assembled[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         field_shift_ff   <= '0;
         riff_left_ff     <= '0;
         chunk_left_ff    <= '0;
         chunk_tag_ff     <= '0;
         channel_count_ff <= '0;
         rate_value_ff    <= '0;
         align_value_ff   <= '0;
         sample_bits_ff   <= '0;
      end else begin
         field_shift_ff   <= field_shift_in;
         riff_left_ff     <= riff_left_in;
         chunk_left_ff    <= chunk_left_in;
         chunk_tag_ff     <= chunk_tag_in;
         channel_count_ff <= channel_count_in;
         rate_value_ff    <= rate_value_in;
         align_value_ff   <= align_value_in;
         sample_bits_ff   <= sample_bits_in;
      end
   end

   // result register, loaded from the state as it stands after this word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         out_status_ff   <= cmd.emit_status;
         out_channels_ff <= channel_count_in;
         out_rate_ff     <= rate_value_in;
         out_align_ff    <= align_value_in;
         out_bits_ff     <= sample_bits_in;
         out_samples_ff  <= cmd.use_quotient ? quotient : '0;
         out_riff_ff     <= riff_left_in;
      end
   end

   always_comb begin
      stat.eq_riff   = assembled == TAG_RIFF;
      stat.eq_wave   = assembled == TAG_WAVE;
      stat.tag_fmt   = chunk_tag_ff == TAG_FMT;
      stat.tag_data  = chunk_tag_ff == TAG_DATA;
      stat.comp_ok   = assembled[15:0] == PCM_CODE;
      stat.bits_ok   = assembled[15:0] == PCM_BITS;
      stat.chan_zero = channel_count_ff == 16'd0;
      stat.riff_zero = riff_left_ff == 32'd0;
      stat.riff_one  = riff_left_ff == 32'd1;
      stat.chunk_one = chunk_left_ff == 32'd1;
      stat.div_done  = div_done;
      stat.out_busy  = rsp_valid_ff;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = out_status_ff;
   assign rsp_channels            = out_channels_ff;
   assign rsp_sample_rate         = out_rate_ff;
   assign rsp_block_align         = out_align_ff;
   assign rsp_bits_per_sample     = out_bits_ff;
   assign rsp_samples_per_channel = out_samples_ff;
   assign rsp_riff_bytes_left     = out_riff_ff;

endmodule

`default_nettype wire

// ----- rtl/core/wavhp_controller.sv -----
// wavhp_controller: parse state machine and byte counter, drives datapath commands
// depends on wavhp_pkg
`default_nettype none

module wavhp_controller
   import wavhp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic [1:0]     req_action,
   output logic                req_ready,
   input  wire wavhp_stat_type stat,
   output wavhp_cmd_type       cmd
);

   phase_type  state_ff, state_in;
   logic [1:0] byte_cnt_ff, byte_cnt_in;

   logic accept;
   logic take_byte;
   logic byte_last;

   assign req_ready = (state_ff != PH_DIV) && (!stat.out_busy || state_ff == PH_DONE);
   assign accept    = req_valid && req_ready;
   assign take_byte = accept && req_action == ACT_BYTE && state_ff != PH_DONE;
   assign byte_last = byte_cnt_ff == field_last(state_ff);

   // next state
   always_comb begin
      state_in    = state_ff;
      byte_cnt_in = byte_cnt_ff;
      if (accept && req_action == ACT_RESTART) begin
         state_in    = PH_RIFF;
         byte_cnt_in = '0;
      end else if (accept && req_action == ACT_END) begin
         state_in = PH_DONE;
      end else if (take_byte && state_ff == PH_SKIP) begin
         if (stat.chunk_one) begin
            state_in = stat.riff_zero ? PH_DONE : PH_ID;
         end
      end else if (take_byte && !byte_last) begin
         byte_cnt_in = byte_cnt_ff + 2'd1;
      end else if (take_byte) begin
         byte_cnt_in = '0;
         case (state_ff)
            PH_RIFF:  state_in = stat.eq_riff ? PH_SIZE : PH_DONE;
            PH_SIZE:  state_in = PH_WAVE;
            PH_WAVE:  state_in = (!stat.eq_wave || stat.riff_one) ? PH_DONE : PH_ID;
            PH_ID:    state_in = PH_CLEN;
            PH_CLEN: begin
               if (stat.tag_fmt) begin
                  state_in = PH_COMP;
               end else if (stat.tag_data && !stat.chan_zero) begin
                  state_in = PH_DIV;
               end else begin
                  state_in = PH_DONE;
               end
            end
            PH_COMP:  state_in = stat.comp_ok ? PH_CHAN : PH_DONE;
            PH_CHAN:  state_in = PH_RATE;
            PH_RATE:  state_in = PH_AVG;
            PH_AVG:   state_in = PH_ALIGN;
            PH_ALIGN: state_in = PH_BITS;
            PH_BITS: begin
               if (!stat.bits_ok) begin
                  state_in = PH_DONE;
               end else if (!stat.chunk_one) begin
                  state_in = PH_SKIP;
               end else begin
                  state_in = stat.riff_zero ? PH_DONE : PH_ID;
               end
            end
            default:  state_in = state_ff;
         endcase
      end else if (state_ff == PH_DIV && stat.div_done) begin
         state_in = PH_DONE;
      end
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      if (accept && req_action == ACT_RESTART) begin
         cmd.clear_all = 1'b1;
      end else if (accept && req_action == ACT_END && state_ff != PH_DONE) begin
         cmd.emit        = 1'b1;
         cmd.emit_status = (state_ff == PH_SKIP && stat.riff_zero) ? ST_EXHAUSTED
                                                                    : ST_TRUNCATED;
      end else if (take_byte && state_ff == PH_SKIP) begin
         cmd.dec_chunk   = 1'b1;
         cmd.emit        = stat.chunk_one && stat.riff_zero;
         cmd.emit_status = ST_EXHAUSTED;
      end else if (take_byte) begin
         cmd.capture     = 1'b1;
         cmd.byte_idx    = byte_cnt_ff;
         cmd.assemble_be = state_ff == PH_RIFF || state_ff == PH_WAVE || state_ff == PH_ID;
         cmd.dec_riff    = state_ff == PH_WAVE || state_ff == PH_ID || state_ff == PH_CLEN;
         cmd.dec_chunk   = state_ff == PH_COMP || state_ff == PH_CHAN || state_ff == PH_RATE
                        || state_ff == PH_AVG || state_ff == PH_ALIGN || state_ff == PH_BITS;
         cmd.field_done  = byte_last;
         if (byte_last) begin
            case (state_ff)
               PH_RIFF: begin
                  cmd.emit        = !stat.eq_riff;
                  cmd.emit_status = ST_BAD_RIFF;
               end
               PH_SIZE:  cmd.load_riff = 1'b1;
               PH_WAVE: begin
                  cmd.emit        = !stat.eq_wave || stat.riff_one;
                  cmd.emit_status = stat.eq_wave ? ST_EXHAUSTED : ST_BAD_WAVE;
               end
               PH_ID:    cmd.load_tag = 1'b1;
               PH_CLEN: begin
                  cmd.load_chunk = 1'b1;
                  if (stat.tag_fmt) begin
                     cmd.emit = 1'b0;
                  end else if (stat.tag_data && !stat.chan_zero) begin
                     cmd.start_div = 1'b1;
                  end else if (stat.tag_data) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_NO_CHANNELS;
                  end else begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_UNKNOWN;
                  end
               end
               PH_COMP: begin
                  cmd.emit        = !stat.comp_ok;
                  cmd.emit_status = ST_COMPRESSION;
               end
               PH_CHAN:  cmd.load_chan = 1'b1;
               PH_RATE:  cmd.load_rate = 1'b1;
               PH_AVG:   cmd.load_rate = 1'b0;
               PH_ALIGN: cmd.load_align = 1'b1;
               PH_BITS: begin
                  cmd.load_bits   = 1'b1;
                  cmd.emit        = !stat.bits_ok || (stat.chunk_one && stat.riff_zero);
                  cmd.emit_status = stat.bits_ok ? ST_EXHAUSTED : ST_BITS;
               end
               default:  cmd.emit = 1'b0;
            endcase
         end
      end else if (state_ff == PH_DIV && stat.div_done) begin
         cmd.emit         = 1'b1;
         cmd.emit_status  = ST_OK;
         cmd.use_quotient = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PH_RIFF;
         byte_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         byte_cnt_ff <= byte_cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/wav_header_parser_unit.sv -----
// wav_header_parser_unit: top level of the riff/wave pcm header parser
// depends on wavhp_pkg, wavhp_req_if, wavhp_rsp_if, wavhp_controller, wavhp_datapath
//
// The parser takes a wave file one byte per word on req_ch and sustains one word per
// clock cycle through the riff, wave, chunk header and fmt fields. When the data chunk
// header completes, the data size is divided by the channel count in an iterative
// divider that retires one quotient bit a cycle, so that req_ch.ready stays low while
// the division runs and the result appears as ready rises; this happens once per
// file. The single result word is held in an output register until rsp_ch takes it.
// Once a result is out, further words are accepted and ignored until a restart word;
// after a restart no word is taken until the held result has been taken.
`default_nettype none

module wav_header_parser_unit
   import wavhp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   wavhp_req_if.sink   req_ch,
   wavhp_rsp_if.source rsp_ch
);

   wavhp_cmd_type  cmd;
   wavhp_stat_type stat;

   wavhp_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wavhp_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .data_byte               (req_ch.data_byte),
      .stat                    (stat),
      .rsp_ready               (rsp_ch.ready),
      .rsp_valid               (rsp_ch.valid),
      .rsp_status              (rsp_ch.status),
      .rsp_channels            (rsp_ch.channels),
      .rsp_sample_rate         (rsp_ch.sample_rate),
      .rsp_block_align         (rsp_ch.block_align),
      .rsp_bits_per_sample     (rsp_ch.bits_per_sample),
      .rsp_samples_per_channel (rsp_ch.samples_per_channel),
      .rsp_riff_bytes_left     (rsp_ch.riff_bytes_left)
   );

   // a result is only produced while the output register is free
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> !stat.out_busy)
      else $error("result produced while output register is occupied");

   // no word is taken while the divider is working
   assert property (@(posedge clock) disable iff (reset) cmd.start_div |=> !req_ch.ready)
      else $error("input ready while division in progress");

   assert property (@(posedge clock) disable iff (reset) stat.div_done |-> cmd.emit)
      else $error("division finished without a result");

   assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid straight after reset");

endmodule

`default_nettype wire
